// ===== src/sdspi_pkg.sv =====
package sdspi_pkg;

    localparam int BLOCK_BYTES_DEF = 512;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CLOCKS, PH_CMD_WAIT, PH_FRAME, PH_RESP, PH_TRAIL, PH_RD_TOKEN,
        PH_RD_DATA, PH_RD_CRC, PH_WR_WAIT, PH_WR_TOKEN, PH_WR_DATA, PH_WR_CRC,
        PH_WR_RESP, PH_STOP_WAIT, PH_STOP_TOKEN
    } phase_t;

    typedef enum logic [3:0] {
        ST_CMD0, ST_CMD8, ST_HC55, ST_HC41, ST_CMD58, ST_PROBE55, ST_PROBE41,
        ST_V1_55, ST_V1_41, ST_MMC1, ST_CMD16, ST_RD_CMD, ST_CMD12,
        ST_WR55, ST_WR23, ST_WR_CMD
    } stage_t;

    typedef enum logic [1:0] {
        JOB_INIT  = 2'd0,
        JOB_READ  = 2'd1,
        JOB_WRITE = 2'd2
    } job_t;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_INIT_TO   = 3'd1;
    localparam logic [2:0] STS_CMD_FAIL  = 3'd2;
    localparam logic [2:0] STS_TOKEN_TO  = 3'd3;
    localparam logic [2:0] STS_WR_REJ    = 3'd4;
    localparam logic [2:0] STS_BUS_BUSY  = 3'd5;
    localparam logic [2:0] STS_UNUSABLE  = 3'd6;

    localparam logic [2:0] CT_NONE = 3'd0;
    localparam logic [2:0] CT_MMC  = 3'd1;
    localparam logic [2:0] CT_SDV1 = 3'd2;
    localparam logic [2:0] CT_SDV2 = 3'd3;
    localparam logic [2:0] CT_SDHC = 3'd4;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] REG_INIT_CLK = 3'd0;
    localparam logic [2:0] REG_CMD0_LIM = 3'd1;
    localparam logic [2:0] REG_BUS_LIM  = 3'd2;
    localparam logic [2:0] REG_RESP_LIM = 3'd3;
    localparam logic [2:0] REG_TOK_LIM  = 3'd4;
    localparam logic [2:0] REG_ACMD_LIM = 3'd5;

    // Configuration limits as seen by the engine.
    typedef struct packed {
        logic [7:0]  init_clock_bytes;
        logic [9:0]  cmd0_retry_limit;
        logic [15:0] bus_idle_poll_limit;
        logic [15:0] response_poll_limit;
        logic [15:0] data_token_poll_limit;
        logic [15:0] acmd41_retry_limit;
    } cfg_t;

    // One input beat.
    typedef struct packed {
        logic [7:0]  write_byte;
        logic [7:0]  rx_byte;
        logic [7:0]  block_count;
        logic [31:0] sector;
        logic [1:0]  op;
        logic        kind;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [2:0] card_type;
        logic [2:0] status;
        logic       done_res;
        logic       block_end;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       write_taken;
        logic       card_selected;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } res_t;

endpackage

// ===== src/sdspi_cfg.sv =====
module sdspi_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output sdspi_pkg::cfg_t    cfg
);
    import sdspi_pkg::*;

    cfg_t cfg_reg;

    // Register file of the init clock count and the poll and retry limits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.init_clock_bytes      <= 8'd20;
            cfg_reg.cmd0_retry_limit      <= 10'd200;
            cfg_reg.bus_idle_poll_limit   <= 16'd1000;
            cfg_reg.response_poll_limit   <= 16'd1000;
            cfg_reg.data_token_poll_limit <= 16'd200;
            cfg_reg.acmd41_retry_limit    <= 16'd65534;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_INIT_CLK: cfg_reg.init_clock_bytes      <= cfg_data[7:0];
                REG_CMD0_LIM: cfg_reg.cmd0_retry_limit      <= cfg_data[9:0];
                REG_BUS_LIM:  cfg_reg.bus_idle_poll_limit   <= cfg_data;
                REG_RESP_LIM: cfg_reg.response_poll_limit   <= cfg_data;
                REG_TOK_LIM:  cfg_reg.data_token_poll_limit <= cfg_data;
                REG_ACMD_LIM: cfg_reg.acmd41_retry_limit    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== src/sdspi_engine.sv =====
module sdspi_engine #(
    parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  sdspi_pkg::item_t   item,
    input  sdspi_pkg::cfg_t    cfg,
    output sdspi_pkg::res_t    res
);
    import sdspi_pkg::*;

    phase_t      phase_reg, phase_next;
    stage_t      stage_reg, stage_next;
    job_t        job_reg, job_next;
    logic [2:0]  dtype_reg, dtype_next;
    logic [15:0] poll_reg, poll_next;
    logic [15:0] retry_reg, retry_next;
    logic [9:0]  bcnt_reg, bcnt_next;
    logic [7:0]  left_reg, left_next;
    logic [5:0]  cidx_reg, cidx_next;
    logic [31:0] carg_reg, carg_next;
    logic [2:0]  fpos_reg, fpos_next;
    logic [31:0] trail_reg, trail_next;
    logic [2:0]  pend_reg, pend_next;
    logic [31:0] addr_reg, addr_next;
    logic        multi_reg, multi_next;

    // Result fields built for this beat.
    logic [7:0] tx;
    logic       txv, wt, rv, be, done;
    logic [7:0] rb;
    logic [2:0] sts;

    logic [15:0] poll_inc, retry_inc;
    logic [9:0]  bcnt_inc;
    logic [7:0]  cnt1, r1v;
    logic [31:0] addr_calc;
    logic        do_r1, ok;

    assign poll_inc  = poll_reg + 16'd1;
    assign retry_inc = retry_reg + 16'd1;
    assign bcnt_inc  = bcnt_reg + 10'd1;
    assign cnt1      = (item.block_count == 8'd0) ? 8'd1 : item.block_count;
    assign addr_calc = (dtype_reg == CT_SDHC) ? item.sector : {item.sector[22:0], 9'd0};

    // Next state and the result of one beat.
    always_comb begin
        phase_next = phase_reg; stage_next = stage_reg; job_next = job_reg;
        dtype_next = dtype_reg; poll_next = poll_reg; retry_next = retry_reg;
        bcnt_next = bcnt_reg; left_next = left_reg; cidx_next = cidx_reg;
        carg_next = carg_reg; fpos_next = fpos_reg; trail_next = trail_reg;
        pend_next = pend_reg; addr_next = addr_reg; multi_next = multi_reg;
        tx = 8'd0; txv = 1'b0; wt = 1'b0; rb = 8'd0; rv = 1'b0; be = 1'b0;
        done = 1'b0; sts = STS_OK;
        do_r1 = 1'b0; r1v = 8'hFF; ok = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (!item.kind) begin
                if (item.op == OP_INIT) begin
                    job_next = JOB_INIT; dtype_next = CT_NONE; bcnt_next = '0;
                    retry_next = '0; phase_next = PH_CLOCKS; tx = 8'hFF; txv = 1'b1;
                end else if (item.op != OP_READ && item.op != OP_WRITE) begin
                    job_next = JOB_READ; done = 1'b1; sts = STS_CMD_FAIL;
                end else begin
                    left_next = cnt1; multi_next = cnt1 > 8'd1; pend_next = STS_OK;
                    addr_next = addr_calc; carg_next = addr_calc;
                    phase_next = PH_CMD_WAIT; poll_next = '0; tx = 8'hFF; txv = 1'b1;
                    if (item.op == OP_READ) begin
                        job_next = JOB_READ; stage_next = ST_RD_CMD;
                        cidx_next = (cnt1 > 8'd1) ? 6'd18 : 6'd17;
                    end else begin
                        job_next = JOB_WRITE;
                        if (cnt1 == 8'd1) begin
                            stage_next = ST_WR_CMD; cidx_next = 6'd24;
                        end else if (dtype_reg != CT_MMC) begin
                            stage_next = ST_WR55; cidx_next = 6'd55; carg_next = '0;
                        end else begin
                            stage_next = ST_WR_CMD; cidx_next = 6'd25;
                        end
                    end
                end
            end
        end else if (item.kind) begin
            case (phase_reg)
                PH_CLOCKS: begin
                    bcnt_next = bcnt_inc;
                    if (bcnt_inc >= {2'd0, cfg.init_clock_bytes}) begin
                        retry_next = '0; stage_next = ST_CMD0; cidx_next = 6'd0;
                        carg_next = '0; phase_next = PH_CMD_WAIT; poll_next = '0;
                    end
                    tx = 8'hFF; txv = 1'b1;
                end
                PH_CMD_WAIT: begin
                    if (item.rx_byte == 8'hFF) begin
                        tx = {2'b01, cidx_reg}; txv = 1'b1; fpos_next = 3'd1;
                        phase_next = PH_FRAME;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= cfg.bus_idle_poll_limit) do_r1 = 1'b1;
                        else begin tx = 8'hFF; txv = 1'b1; end
                    end
                end
                PH_FRAME: begin
                    fpos_next = fpos_reg + 3'd1; txv = 1'b1;
                    case (fpos_reg)
                        3'd1: tx = carg_reg[31:24];
                        3'd2: tx = carg_reg[23:16];
                        3'd3: tx = carg_reg[15:8];
                        3'd4: tx = carg_reg[7:0];
                        3'd5: tx = (cidx_reg == 6'd0) ? 8'h95 :
                                   (cidx_reg == 6'd8) ? 8'h87 : 8'h01;
                        default: begin
                            tx = 8'hFF;
                            if (!(fpos_reg == 3'd6 && cidx_reg == 6'd12)) begin
                                fpos_next = fpos_reg; phase_next = PH_RESP; poll_next = '0;
                            end
                        end
                    endcase
                end
                PH_RESP: begin
                    if (!item.rx_byte[7]) begin
                        do_r1 = 1'b1; r1v = item.rx_byte;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= cfg.response_poll_limit) do_r1 = 1'b1;
                        else begin tx = 8'hFF; txv = 1'b1; end
                    end
                end
                PH_TRAIL: begin
                    trail_next = {trail_reg[23:0], item.rx_byte};
                    bcnt_next = bcnt_inc;
                    if (bcnt_inc < 10'd4) begin
                        tx = 8'hFF; txv = 1'b1;
                    end else if (stage_reg == ST_CMD8) begin
                        if (trail_next[15:0] == 16'h01AA) begin
                            retry_next = '0; stage_next = ST_HC55; cidx_next = 6'd55;
                            carg_next = '0; phase_next = PH_CMD_WAIT; poll_next = '0;
                            tx = 8'hFF; txv = 1'b1;
                        end else begin
                            phase_next = PH_IDLE; done = 1'b1; sts = STS_UNUSABLE;
                        end
                    end else begin
                        dtype_next = trail_next[30] ? CT_SDHC : CT_SDV2;
                        phase_next = PH_IDLE; done = 1'b1;
                    end
                end
                PH_RD_TOKEN: begin
                    if (item.rx_byte == 8'hFE) begin
                        phase_next = PH_RD_DATA; bcnt_next = '0; tx = 8'hFF; txv = 1'b1;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= cfg.data_token_poll_limit) begin
                            if (multi_reg) begin
                                pend_next = STS_TOKEN_TO; stage_next = ST_CMD12;
                                cidx_next = 6'd12; carg_next = '0;
                                phase_next = PH_CMD_WAIT; poll_next = '0;
                                tx = 8'hFF; txv = 1'b1;
                            end else begin
                                phase_next = PH_IDLE; done = 1'b1; sts = STS_TOKEN_TO;
                            end
                        end else begin tx = 8'hFF; txv = 1'b1; end
                    end
                end
                PH_RD_DATA: begin
                    rb = item.rx_byte; rv = 1'b1; bcnt_next = bcnt_inc;
                    if (bcnt_inc >= 10'(BLOCK_BYTES)) begin
                        be = 1'b1; phase_next = PH_RD_CRC; bcnt_next = '0;
                    end
                    tx = 8'hFF; txv = 1'b1;
                end
                PH_RD_CRC: begin
                    if (bcnt_reg == 10'd0) begin
                        bcnt_next = 10'd1; tx = 8'hFF; txv = 1'b1;
                    end else begin
                        left_next = left_reg - 8'd1;
                        if (left_next != 8'd0) begin
                            phase_next = PH_RD_TOKEN; poll_next = '0; tx = 8'hFF; txv = 1'b1;
                        end else if (multi_reg) begin
                            pend_next = STS_OK; stage_next = ST_CMD12; cidx_next = 6'd12;
                            carg_next = '0; phase_next = PH_CMD_WAIT; poll_next = '0;
                            tx = 8'hFF; txv = 1'b1;
                        end else begin
                            phase_next = PH_IDLE; done = 1'b1;
                        end
                    end
                end
                PH_WR_WAIT: begin
                    if (item.rx_byte == 8'hFF) begin
                        tx = multi_reg ? 8'hFC : 8'hFE; txv = 1'b1; phase_next = PH_WR_TOKEN;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= cfg.bus_idle_poll_limit) begin
                            if (multi_reg) begin
                                pend_next = STS_BUS_BUSY; phase_next = PH_STOP_WAIT;
                                poll_next = '0; tx = 8'hFF; txv = 1'b1;
                            end else begin
                                phase_next = PH_IDLE; done = 1'b1; sts = STS_BUS_BUSY;
                            end
                        end else begin tx = 8'hFF; txv = 1'b1; end
                    end
                end
                PH_WR_TOKEN: begin
                    tx = item.write_byte; txv = 1'b1; wt = 1'b1; bcnt_next = 10'd1;
                    phase_next = PH_WR_DATA;
                end
                PH_WR_DATA: begin
                    txv = 1'b1;
                    if (bcnt_reg < 10'(BLOCK_BYTES)) begin
                        tx = item.write_byte; wt = 1'b1; bcnt_next = bcnt_inc;
                    end else begin
                        tx = 8'hFF; phase_next = PH_WR_CRC; bcnt_next = '0;
                    end
                end
                PH_WR_CRC: begin
                    if (bcnt_reg == 10'd0) bcnt_next = 10'd1;
                    else phase_next = PH_WR_RESP;
                    tx = 8'hFF; txv = 1'b1;
                end
                PH_WR_RESP: begin
                    ok = item.rx_byte[4:0] == 5'h05;
                    if (!multi_reg) begin
                        phase_next = PH_IDLE; done = 1'b1; sts = ok ? STS_OK : STS_WR_REJ;
                    end else begin
                        poll_next = '0; tx = 8'hFF; txv = 1'b1;
                        if (!ok) begin
                            pend_next = STS_WR_REJ; phase_next = PH_STOP_WAIT;
                        end else begin
                            left_next = left_reg - 8'd1;
                            phase_next = (left_next == 8'd0) ? PH_STOP_WAIT : PH_WR_WAIT;
                        end
                    end
                end
                PH_STOP_WAIT: begin
                    if (item.rx_byte == 8'hFF) begin
                        tx = 8'hFD; txv = 1'b1; phase_next = PH_STOP_TOKEN;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= cfg.bus_idle_poll_limit) begin
                            phase_next = PH_IDLE; done = 1'b1;
                            sts = (pend_reg != STS_OK) ? pend_reg : STS_BUS_BUSY;
                        end else begin tx = 8'hFF; txv = 1'b1; end
                    end
                end
                PH_STOP_TOKEN: begin
                    phase_next = PH_IDLE; done = 1'b1; sts = pend_reg;
                end
                default: ;
            endcase

            // R1 handling per command stage; a timeout arrives as 0xFF.
            if (do_r1) begin
                phase_next = PH_CMD_WAIT; poll_next = '0; tx = 8'hFF; txv = 1'b1;
                carg_next = '0;
                case (stage_reg)
                    ST_CMD0: begin
                        if (r1v == 8'h01) begin
                            stage_next = ST_CMD8; cidx_next = 6'd8; carg_next = 32'h1AA;
                        end else begin
                            retry_next = retry_inc; cidx_next = 6'd0;
                            if (retry_inc >= {6'd0, cfg.cmd0_retry_limit}) begin
                                done = 1'b1; sts = STS_INIT_TO;
                            end
                        end
                    end
                    ST_CMD8: begin
                        if (r1v == 8'h01) begin
                            phase_next = PH_TRAIL; bcnt_next = '0; trail_next = '0;
                        end else begin
                            stage_next = ST_PROBE55; cidx_next = 6'd55;
                        end
                    end
                    ST_HC55: begin
                        stage_next = ST_HC41; cidx_next = 6'd41; carg_next = 32'h4000_0000;
                    end
                    ST_HC41: begin
                        if (r1v == 8'h00) begin
                            stage_next = ST_CMD58; cidx_next = 6'd58;
                        end else begin
                            retry_next = retry_inc; stage_next = ST_HC55; cidx_next = 6'd55;
                            if (retry_inc >= cfg.acmd41_retry_limit) begin
                                done = 1'b1; sts = STS_INIT_TO;
                            end
                        end
                    end
                    ST_CMD58: begin
                        if (r1v == 8'h00) begin
                            phase_next = PH_TRAIL; bcnt_next = '0; trail_next = '0;
                        end else begin
                            done = 1'b1; sts = STS_CMD_FAIL;
                        end
                    end
                    ST_PROBE55: begin
                        stage_next = ST_PROBE41; cidx_next = 6'd41;
                    end
                    ST_PROBE41: begin
                        retry_next = '0;
                        if (r1v <= 8'h01) begin
                            dtype_next = CT_SDV1; stage_next = ST_V1_55; cidx_next = 6'd55;
                        end else begin
                            dtype_next = CT_MMC; stage_next = ST_MMC1; cidx_next = 6'd1;
                        end
                    end
                    ST_V1_55: begin
                        stage_next = ST_V1_41; cidx_next = 6'd41;
                    end
                    ST_V1_41, ST_MMC1: begin
                        if (r1v == 8'h00) begin
                            stage_next = ST_CMD16; cidx_next = 6'd16;
                            carg_next = 32'(BLOCK_BYTES);
                        end else begin
                            retry_next = retry_inc;
                            if (stage_reg == ST_V1_41) begin
                                stage_next = ST_V1_55; cidx_next = 6'd55;
                            end else cidx_next = 6'd1;
                            if (retry_inc >= cfg.acmd41_retry_limit) begin
                                done = 1'b1; sts = STS_INIT_TO;
                            end
                        end
                    end
                    ST_CMD16: begin
                        done = 1'b1; sts = (r1v == 8'h00) ? STS_OK : STS_UNUSABLE;
                    end
                    ST_RD_CMD: begin
                        if (r1v != 8'h00) begin
                            done = 1'b1; sts = STS_CMD_FAIL;
                        end else phase_next = PH_RD_TOKEN;
                    end
                    ST_CMD12: begin
                        done = 1'b1; sts = pend_reg;
                    end
                    ST_WR55: begin
                        stage_next = ST_WR23; cidx_next = 6'd23; carg_next = {24'd0, left_reg};
                    end
                    ST_WR23: begin
                        stage_next = ST_WR_CMD; cidx_next = 6'd25; carg_next = addr_reg;
                    end
                    default: begin
                        if (r1v != 8'h00) begin
                            done = 1'b1; sts = STS_CMD_FAIL;
                        end else phase_next = PH_WR_WAIT;
                    end
                endcase
                // Finishing leaves the command registers as they were.
                if (done) begin
                    phase_next = PH_IDLE; tx = 8'h00; txv = 1'b0;
                    cidx_next = cidx_reg; carg_next = carg_reg; stage_next = stage_reg;
                end
            end
        end

        // A failed initialization forgets the card.
        if (done && job_next == JOB_INIT && sts != STS_OK) dtype_next = CT_NONE;
    end

    // Result fields of this beat.
    always_comb begin
        res.tx_byte       = tx;
        res.tx_valid      = txv;
        res.card_selected = phase_next != PH_IDLE && phase_next != PH_CLOCKS;
        res.write_taken   = wt;
        res.read_byte     = rb;
        res.read_valid    = rv;
        res.block_end     = be;
        res.done_res      = done;
        res.status        = sts;
        res.card_type     = dtype_next;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; stage_reg <= ST_CMD0; job_reg <= JOB_INIT;
            dtype_reg <= CT_NONE; poll_reg <= '0; retry_reg <= '0; bcnt_reg <= '0;
            left_reg <= '0; cidx_reg <= '0; carg_reg <= '0; fpos_reg <= '0;
            trail_reg <= '0; pend_reg <= '0; addr_reg <= '0; multi_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next; stage_reg <= stage_next; job_reg <= job_next;
            dtype_reg <= dtype_next; poll_reg <= poll_next; retry_reg <= retry_next;
            bcnt_reg <= bcnt_next; left_reg <= left_next; cidx_reg <= cidx_next;
            carg_reg <= carg_next; fpos_reg <= fpos_next; trail_reg <= trail_next;
            pend_reg <= pend_next; addr_reg <= addr_next; multi_reg <= multi_next;
        end
    end
endmodule

// ===== src/sd_card_spi_mode_engine_core.sv =====
// Channel | Beat fields (low bit up)                                  | Handshake
// s_axis  | tuser: kind                                               | tvalid/tready
//         | tdata: op, sector, block_count, rx_byte, write_byte       |
// m_axis  | tdata: tx_byte, tx_valid, card_selected, write_taken,     | tvalid/tready
//         |        read_byte, read_valid, done_res, status, card_type |
//         | tlast: block_end                                          |
// cfg     | cfg_we, cfg_index, cfg_data                               | write only
// An accepted input beat sits in the input register, and its result is computed
// from there into the output register, so a result is offered once its beat has moved
// on from the input register; one beat per cycle is sustained while m_axis_tready is high.
// In use a beat arrives once per SPI byte exchange.
// The engine state advances when a result moves into the output register; while an
// output beat waits untaken, a full input register holds and s_axis_tready drops.
// Reset is synchronous on aresetn low, clears the control state and restores the
// default limits.
module sd_card_spi_mode_engine_core #(
    parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[0]
    input  logic        s_axis_tuser,
    // op[1:0], sector[33:2], block_count[41:34], rx_byte[49:42],
    // write_byte[57:50], zero fill up to bit 63
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], tx_valid[8], card_selected[9], write_taken[10],
    // read_byte[18:11], read_valid[19], done_res[20], status[23:21],
    // card_type[26:24], zero fill up to bit 31
    output logic [31:0] m_axis_tdata,
    // block_end
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sdspi_pkg::*;

    cfg_t  cfg;
    item_t in_reg;
    logic  in_valid_reg;
    res_t  res, out_reg;
    logic  out_valid_reg;
    logic  step, out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    sdspi_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
    );

    sdspi_engine #(.BLOCK_BYTES(BLOCK_BYTES)) u_engine (
        .aclk(aclk), .aresetn(aresetn), .step(step), .item(in_reg),
        .cfg(cfg), .res(res)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_reg <= {s_axis_tdata[57:0], s_axis_tuser};
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.block_end;
    assign m_axis_tdata  = {5'd0, out_reg.card_type, out_reg.status, out_reg.done_res,
                            out_reg.read_valid, out_reg.read_byte, out_reg.write_taken,
                            out_reg.card_selected, out_reg.tx_valid, out_reg.tx_byte};
endmodule

// ===== src/sdspi_checker.sv =====
module sdspi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // An output beat waiting must hold its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tlast, m_axis_tdata}))
        else $error("output beat changed while stalled");

    // A finished request never asks for another exchange.
    a_done_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[20] |-> !m_axis_tdata[8])
        else $error("done beat with tx_valid");

    // Read data and write data never share a beat.
    a_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[19] && m_axis_tdata[10]))
        else $error("read and write in one beat");

    // The end of a block always comes with read data.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[19])
        else $error("block end without read data");

    // An empty output side keeps the input open.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && $past(!m_axis_tvalid) && aresetn && $past(aresetn)
        |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

bind sd_card_spi_mode_engine_core sdspi_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
